[sv/nfa_sa_pkg.sv]
package nfa_sa_pkg;

  localparam int NUM_STATES  = 16;
  localparam int NUM_SYMBOLS = 26;
  localparam int TABLE_DEPTH = NUM_STATES * NUM_SYMBOLS;

  localparam int STATE_W  = 4;
  localparam int SYMBOL_W = 5;
  localparam int SET_W    = 16;
  localparam int ADDR_W   = $clog2(TABLE_DEPTH);
  localparam int Q_W      = $clog2(NUM_STATES);

  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 24;
  localparam int CFG_DATA_W  = 16;

  typedef enum logic [1:0] {
    MODE_EDGE   = 2'd0,
    MODE_BEGIN  = 2'd1,
    MODE_SYMBOL = 2'd2,
    MODE_END    = 2'd3
  } mode_t;

  typedef enum logic {
    CFG_INIT_STATE = 1'b0,
    CFG_FINAL_MASK = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic load;
    logic clear_step;
    logic edge_rd;
    logic edge_wr;
    logic scan_rd;
    logic commit;
  } nfa_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic scan_last;
    logic out_free;
  } nfa_sts_t;

endpackage

[sv/nfa_sa_ctrl.sv]
module nfa_sa_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  nfa_sa_pkg::mode_t   in_mode,
  input  nfa_sa_pkg::nfa_sts_t sts,
  output nfa_sa_pkg::nfa_cmd_t cmd
);
  import nfa_sa_pkg::*;

  typedef enum logic [6:0] {
    S_CLEAR   = 7'b0000001,
    S_IDLE    = 7'b0000010,
    S_EDGE_RD = 7'b0000100,
    S_EDGE_WR = 7'b0001000,
    S_SCAN    = 7'b0010000,
    S_DRAIN   = 7'b0100000,
    S_RESP    = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (sts.clear_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load = 1'b1;
          unique case (in_mode)
            MODE_EDGE:   state_nxt = S_EDGE_RD;
            MODE_SYMBOL: state_nxt = S_SCAN;
            default:     state_nxt = S_RESP;
          endcase
        end
      end
      S_EDGE_RD: begin
        cmd.edge_rd = 1'b1;
        state_nxt   = S_EDGE_WR;
      end
      S_EDGE_WR: begin
        cmd.edge_wr = 1'b1;
        state_nxt   = S_RESP;
      end
      S_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (sts.scan_last) state_nxt = S_DRAIN;
      end
      S_DRAIN: begin
        state_nxt = S_RESP;
      end
      S_RESP: begin
        // hold the result until the output register frees up
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[sv/nfa_sa_dp.sv]
module nfa_sa_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  nfa_sa_pkg::nfa_cmd_t                cmd,
  output nfa_sa_pkg::nfa_sts_t                sts,
  input  nfa_sa_pkg::mode_t                   in_mode,
  input  logic [nfa_sa_pkg::STATE_W-1:0]      in_from,
  input  logic [nfa_sa_pkg::STATE_W-1:0]      in_to,
  input  logic [nfa_sa_pkg::SYMBOL_W-1:0]     in_symbol,
  input  logic                                cfg_we,
  input  nfa_sa_pkg::cfg_idx_t                cfg_idx,
  input  logic [nfa_sa_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [nfa_sa_pkg::SET_W-1:0]        out_set,
  output logic                                out_accepted,
  output logic                                out_done
);
  import nfa_sa_pkg::*;

  logic [SET_W-1:0]    mem [0:TABLE_DEPTH-1];
  logic [SET_W-1:0]    rd_data_r;

  mode_t               mode_r;
  logic [STATE_W-1:0]  from_r, to_r;
  logic [SYMBOL_W-1:0] sym_r;
  logic [STATE_W-1:0]  start_r;
  logic [SET_W-1:0]    final_r;
  logic [SET_W-1:0]    set_r, set_nxt;
  logic [SET_W-1:0]    acc_r;
  logic [ADDR_W-1:0]   addr_r;
  logic [Q_W-1:0]      q_r, qd_r;
  logic                scan_vld_r;
  logic                out_valid_r;
  logic [SET_W-1:0]    out_set_r;
  logic                out_acc_r, out_done_r;

  logic                edge_ok, sym_ok, scan_in_range;
  logic [ADDR_W-1:0]   edge_addr;
  logic                mem_we, mem_re;
  logic [ADDR_W-1:0]   mem_waddr, mem_raddr;
  logic [SET_W-1:0]    mem_wdata;

  assign sym_ok    = (int'(sym_r) < NUM_SYMBOLS);
  assign edge_ok   = sym_ok && (int'(from_r) < NUM_STATES) && (int'(to_r) < NUM_STATES);
  assign edge_addr = ADDR_W'(from_r) * ADDR_W'(NUM_SYMBOLS) + ADDR_W'(sym_r);
  assign scan_in_range = (int'(addr_r) < TABLE_DEPTH);

  assign mem_we    = cmd.clear_step || (cmd.edge_wr && edge_ok);
  assign mem_waddr = cmd.clear_step ? addr_r : edge_addr;
  assign mem_wdata = cmd.clear_step ? '0 : (rd_data_r | (SET_W'(1) << to_r));
  assign mem_re    = (cmd.edge_rd && edge_ok) || (cmd.scan_rd && scan_in_range);
  assign mem_raddr = cmd.edge_rd ? edge_addr : addr_r;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rd_data_r <= mem[mem_raddr];
  end

  assign sts.clear_last = (addr_r == ADDR_W'(TABLE_DEPTH - 1));
  assign sts.scan_last  = (q_r == Q_W'(NUM_STATES - 1));
  assign sts.out_free   = !out_valid_r || out_ready;

  always_comb begin
    case (mode_r)
      MODE_BEGIN:  set_nxt = (int'(start_r) < NUM_STATES) ? (SET_W'(1) << start_r) : '0;
      MODE_SYMBOL: set_nxt = sym_ok ? acc_r : '0;
      default:     set_nxt = set_r;
    endcase
  end

  // item capture and table walk
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r <= in_mode;
      from_r <= in_from;
      to_r   <= in_to;
      sym_r  <= in_symbol;
    end
    if (cmd.load) begin
      q_r <= '0;
    end else if (cmd.scan_rd) begin
      q_r <= q_r + Q_W'(1);
    end
    qd_r <= q_r;
    if (cmd.load) begin
      acc_r <= '0;
    end else if (scan_vld_r && set_r[qd_r]) begin
      acc_r <= acc_r | rd_data_r;
    end
    if (cmd.commit) begin
      out_set_r  <= set_nxt;
      out_acc_r  <= |(set_nxt & final_r);
      out_done_r <= (mode_r == MODE_END);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r      <= '0;
      scan_vld_r  <= 1'b0;
      set_r       <= '0;
      start_r     <= '0;
      final_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      scan_vld_r <= cmd.scan_rd;
      if (cmd.clear_step) begin
        addr_r <= addr_r + ADDR_W'(1);
      end else if (cmd.load) begin
        addr_r <= ADDR_W'(in_symbol);
      end else if (cmd.scan_rd) begin
        addr_r <= addr_r + ADDR_W'(NUM_SYMBOLS);
      end
      if (cmd.commit) begin
        // an end item reports the judged set, then drops it
        set_r <= (mode_r == MODE_END) ? '0 : set_nxt;
      end
      if (cfg_we) begin
        unique case (cfg_idx)
          CFG_INIT_STATE: start_r <= cfg_wdata[STATE_W-1:0];
          CFG_FINAL_MASK: final_r <= cfg_wdata[SET_W-1:0];
          default:        ;
        endcase
      end
      if (cmd.commit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid    = out_valid_r;
  assign out_set      = out_set_r;
  assign out_accepted = out_acc_r;
  assign out_done     = out_done_r;

  a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (!out_valid_r || out_ready))
    else $error("result committed over a pending word");

  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && mode_r == MODE_END) |=> (set_r == '0))
    else $error("active set not cleared after end item");

  a_wr_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.edge_wr |-> $past(cmd.edge_rd))
    else $error("edge write without preceding read");

  a_no_clear_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear_step |-> !(cmd.load || cmd.edge_wr || cmd.scan_rd || cmd.commit))
    else $error("table clear overlaps item work");

endmodule

[sv/nfa_string_acceptor.sv]
// NFA string acceptor.
// Input stream (in_*): in_tuser carries the item kind (add edge, begin string,
// consume symbol, end string); in_tdata carries from_state, to_state, symbol.
// Output stream (out_*): one word per input item with the active state set,
// the acceptance flag and, on tlast, the end-of-string marker.
// Config channel (cfg_*): index 0 writes the start state, index 1 final_mask;
// always ready, write only while no item is in flight.
// An edge item does a table read-modify-write; a symbol item reads one
// successor row per state (16 reads on the single table read port), then
// drains the read pipe. One item is in work at a time, so the next word is
// taken only once the result of the current one has been committed.
// After reset the 416-entry edge table is cleared one entry per cycle;
// in_tready stays low until the clear ends; cfg writes are still taken.
// The result sits in an output register: a new item is accepted while it
// waits, and if the receiver stalls, the next result is held until the
// register frees up.
module nfa_string_acceptor (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [nfa_sa_pkg::IN_TDATA_W-1:0]    in_tdata,  // from_state, to_state, symbol
  input  logic [1:0]                           in_tuser,  // mode
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [nfa_sa_pkg::OUT_TDATA_W-1:0]   out_tdata, // active_set, accepted
  output logic                                 out_tlast,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic                                 cfg_index,
  input  logic [nfa_sa_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import nfa_sa_pkg::*;

  nfa_cmd_t            cmd;
  nfa_sts_t            sts;
  mode_t               in_mode;
  logic [SET_W-1:0]    out_set;
  logic                out_accepted;

  assign in_mode   = mode_t'(in_tuser);
  assign cfg_ready = 1'b1;

  nfa_sa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_mode   (in_mode),
    .sts       (sts),
    .cmd       (cmd)
  );

  nfa_sa_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .in_mode      (in_mode),
    .in_from      (in_tdata[STATE_W-1:0]),
    .in_to        (in_tdata[2*STATE_W-1:STATE_W]),
    .in_symbol    (in_tdata[2*STATE_W+SYMBOL_W-1:2*STATE_W]),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_idx      (cfg_idx_t'(cfg_index)),
    .cfg_wdata    (cfg_data),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_set      (out_set),
    .out_accepted (out_accepted),
    .out_done     (out_tlast)
  );

  assign out_tdata = {{(OUT_TDATA_W - SET_W - 1){1'b0}}, out_accepted, out_set};

endmodule

[verif/nfa_string_acceptor_tb.sv]
module nfa_string_acceptor_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import nfa_sa_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int TAIL_CYCLES = 40;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 130;

  typedef struct {
    logic [SET_W-1:0] active_set;
    logic             accepted;
    logic             string_done;
  } nfa_report_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;  // src [3:0], dst [7:4], symbol [12:8], zero pad
  logic [1:0]             in_tuser;  // mode
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata; // active_set [15:0], accepted [16], zero pad
  logic                   out_tlast;
  logic                   cfg_valid;
  logic                   cfg_ready;
  cfg_idx_t               cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  // predictor state
  logic [SET_W-1:0]   succ_tbl [TABLE_DEPTH];
  logic [SET_W-1:0]   live_set;
  logic [STATE_W-1:0] cfg_start;
  logic [SET_W-1:0]   cfg_final;

  nfa_report_t report_q[$];
  int          fail_count;
  int          cycle_count;
  int          items_sent;
  int          sink_hold_cycles;
  bit          sender_quiet;
  bit          sink_quiet;

  nfa_string_acceptor i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Apply one accepted word to the automaton copy and return the report it causes.
  function automatic nfa_report_t nfa_advance(mode_t mode, logic [STATE_W-1:0] src,
                                              logic [STATE_W-1:0] dst,
                                              logic [SYMBOL_W-1:0] sym);
    nfa_report_t      rep;
    logic [SET_W-1:0] nxt;
    case (mode)
      MODE_EDGE: begin
        if (sym < NUM_SYMBOLS)
          succ_tbl[int'(src) * NUM_SYMBOLS + int'(sym)] |= SET_W'(1) << dst;
      end
      MODE_BEGIN: begin
        live_set = SET_W'(1) << cfg_start;
      end
      MODE_SYMBOL: begin
        nxt = '0;
        if (sym < NUM_SYMBOLS)
          for (int q = 0; q < NUM_STATES; q++)
            if (live_set[q]) nxt |= succ_tbl[q * NUM_SYMBOLS + int'(sym)];
        live_set = nxt;
      end
      default: ;
    endcase
    rep.active_set  = live_set;
    rep.accepted    = |(live_set & cfg_final);
    rep.string_done = (mode == MODE_END);
    if (mode == MODE_END) live_set = '0;
    return rep;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (sender_quiet || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Called at a falling edge; returns at a falling edge after the word went in.
  task automatic push_item(mode_t mode, logic [STATE_W-1:0] src, logic [STATE_W-1:0] dst,
                           logic [SYMBOL_W-1:0] sym);
    int          gap;
    nfa_report_t rep;
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= {3'b000, sym, dst, src};
    do @(posedge clk); while (!in_tready);
    rep = nfa_advance(mode, src, dst, sym);
    report_q.insert(report_q.size(), rep);
    items_sent++;
    @(negedge clk);
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_INIT_STATE) cfg_start = value[STATE_W-1:0];
    else cfg_final = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Hold the sender until every expected word is back and the block has settled.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (report_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  function automatic logic [SYMBOL_W-1:0] pick_symbol(int base);
    int r;
    r = $urandom_range(0, 99);
    if (r < 90) return SYMBOL_W'(base + $urandom_range(0, 3));
    if (r < 95) return SYMBOL_W'($urandom_range(0, NUM_SYMBOLS - 1));
    return SYMBOL_W'($urandom_range(NUM_SYMBOLS, 31));
  endfunction

  task automatic send_string(int base, int max_len);
    int len;
    len = $urandom_range(0, max_len);
    if ($urandom_range(0, 99) >= 5) push_item(MODE_BEGIN, 4'($urandom), 4'($urandom), 5'($urandom));
    repeat (len) push_item(MODE_SYMBOL, 4'($urandom), 4'($urandom), pick_symbol(base));
    if ($urandom_range(0, 99) >= 5) push_item(MODE_END, 4'($urandom), 4'($urandom), 5'($urandom));
  endtask

  task automatic test_directed();
    write_reg(CFG_INIT_STATE, 16'h0000);
    write_reg(CFG_FINAL_MASK, 16'h8000);
    push_item(MODE_EDGE, 4'd0, 4'd1, 5'd0);
    push_item(MODE_EDGE, 4'd1, 4'd15, 5'd1);
    push_item(MODE_EDGE, 4'd15, 4'd0, 5'd25);
    push_item(MODE_EDGE, 4'd0, 4'd1, 5'd0);     // duplicate edge
    push_item(MODE_EDGE, 4'd3, 4'd4, 5'd31);    // symbol out of range: dropped
    push_item(MODE_EDGE, 4'd2, 4'd5, 5'd26);
    push_item(MODE_BEGIN, 4'd15, 4'd15, 5'd31);
    push_item(MODE_SYMBOL, 4'd0, 4'd0, 5'd0);
    push_item(MODE_SYMBOL, 4'd0, 4'd0, 5'd1);
    push_item(MODE_END, 4'd0, 4'd0, 5'd0);
    push_item(MODE_SYMBOL, 4'd0, 4'd0, 5'd0);   // consume with no string open
    push_item(MODE_END, 4'd0, 4'd0, 5'd0);
    push_item(MODE_BEGIN, 4'd0, 4'd0, 5'd0);
    push_item(MODE_SYMBOL, 4'd0, 4'd0, 5'd31);  // no edge carries this symbol
    push_item(MODE_SYMBOL, 4'd0, 4'd0, 5'd0);
    push_item(MODE_END, 4'd0, 4'd0, 5'd0);
    wait_drained();
    write_reg(CFG_INIT_STATE, 16'hFFFF);
    write_reg(CFG_FINAL_MASK, 16'hFFFF);
    push_item(MODE_BEGIN, 4'd0, 4'd0, 5'd0);
    push_item(MODE_SYMBOL, 4'd0, 4'd0, 5'd25);
    push_item(MODE_SYMBOL, 4'd0, 4'd0, 5'd0);
    push_item(MODE_END, 4'd0, 4'd0, 5'd0);
    push_item(MODE_END, 4'd0, 4'd0, 5'd0);
    wait_drained();
  endtask

  task automatic test_random_strings();
    int phase_end;
    int base;
    int r;
    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      case (p)
        0: begin
          write_reg(CFG_INIT_STATE, 16'h0000);
          write_reg(CFG_FINAL_MASK, 16'h0000);
        end
        1: begin
          write_reg(CFG_INIT_STATE, 16'h000F);
          write_reg(CFG_FINAL_MASK, 16'hFFFF);
        end
        default: begin
          write_reg(CFG_INIT_STATE, CFG_DATA_W'($urandom));
          if (p % 2) write_reg(CFG_FINAL_MASK, CFG_DATA_W'($urandom));
          else write_reg(CFG_FINAL_MASK, (16'h1 << $urandom_range(0, 15)) |
                                         (16'h1 << $urandom_range(0, 15)));
        end
      endcase
      sender_quiet = (p == 3);
      sink_quiet   = (p == 3) || (p == 6);
      base = $urandom_range(0, NUM_SYMBOLS - 4);
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) begin
        r = $urandom_range(0, 99);
        if (r < 10) begin
          push_item(mode_t'($urandom_range(0, 3)), 4'($urandom), 4'($urandom),
                    5'($urandom));
        end else if (r < 25) begin
          repeat ($urandom_range(1, 3))
            push_item(MODE_EDGE, 4'($urandom), 4'($urandom),
                      ($urandom_range(0, 99) < 85) ? SYMBOL_W'(base + $urandom_range(0, 3))
                                                   : SYMBOL_W'($urandom));
        end else begin
          send_string(base, 8);
        end
      end
    end
    sender_quiet = 0;
    sink_quiet   = 0;
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering words.
  task automatic test_backpressure();
    int base;
    wait_drained();
    base = $urandom_range(0, NUM_SYMBOLS - 4);
    sender_quiet = 1;
    sink_hold_cycles = 400;
    repeat (6) send_string(base, 6);
    sender_quiet = 0;
    wait_drained();
  endtask

  // Drive out_tready: random stalls, or a counted hold-off when asked.
  initial begin : sink_drive
    int stall;
    int r;
    stall = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (sink_hold_cycles > 0) begin
        out_tready <= 1'b0;
        sink_hold_cycles--;
      end else if (stall > 0) begin
        out_tready <= 1'b0;
        stall--;
      end else begin
        r = $urandom_range(0, 99);
        if (sink_quiet || r < 75) stall = 0;
        else if (r < 93) stall = $urandom_range(1, 3);
        else if (r < 99) stall = $urandom_range(4, 10);
        else stall = $urandom_range(20, 50);
        out_tready <= (stall == 0);
        if (stall > 0) stall--;
      end
    end
  end

  always @(posedge clk) begin : result_check
    nfa_report_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      if (report_q.size() == 0) begin
        $display("%0t: unexpected word: expected none, got active_set %h accepted %b done %b",
                 $time, out_tdata[SET_W-1:0], out_tdata[SET_W], out_tlast);
        fail_count++;
      end else begin
        exp_r = report_q.pop_front();
        if (out_tdata[SET_W-1:0] !== exp_r.active_set) begin
          $display("%0t: active_set expected %h, got %h", $time, exp_r.active_set,
                   out_tdata[SET_W-1:0]);
          fail_count++;
        end
        if (out_tdata[SET_W] !== exp_r.accepted) begin
          $display("%0t: accepted expected %b, got %b", $time, exp_r.accepted,
                   out_tdata[SET_W]);
          fail_count++;
        end
        if (out_tlast !== exp_r.string_done) begin
          $display("%0t: string_done expected %b, got %b", $time, exp_r.string_done,
                   out_tlast);
          fail_count++;
        end
      end
    end
  end

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = MODE_EDGE;
    cfg_valid = 1'b0;
    cfg_index = CFG_INIT_STATE;
    cfg_data  = '0;
    fail_count = 0;
    cycle_count = 0;
    items_sent = 0;
    sink_hold_cycles = 0;
    sender_quiet = 0;
    sink_quiet = 0;
    live_set = '0;
    cfg_start = '0;
    cfg_final = '0;
    foreach (succ_tbl[i]) succ_tbl[i] = '0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed();
    test_random_strings();
    test_backpressure();

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && report_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[nfa_string_acceptor.f]
sv/nfa_sa_pkg.sv
sv/nfa_sa_ctrl.sv
sv/nfa_sa_dp.sv
sv/nfa_string_acceptor.sv
verif/nfa_string_acceptor_tb.sv
